>>> rtl/core/stream_tag_replace_top_assert.svh
// Assertion macros used by the stream tag replace sequencer.
`ifndef STREAM_TAG_REPLACE_TOP_ASSERT_SVH
`define STREAM_TAG_REPLACE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define STP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stream_tag_replace: same-cycle check failed");
`define STP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stream_tag_replace: next-cycle check failed");
`else
`define STP_ASSERT_NOW(label, ante, cons)
`define STP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/core/stp_pkg.sv
// Shared types, constants and helper functions of the stream tag replace block.
package stp_pkg;

    localparam int MAX_TAG_LEN   = 8;
    localparam int MAX_VALUE_LEN = 8;
    localparam int BYTE_W        = 8;
    localparam int NUM_BYTES     = 8;
    localparam int WORD_W        = NUM_BYTES * BYTE_W;
    localparam int IDX_W         = $clog2(NUM_BYTES);
    localparam int LEN_W         = 4;
    localparam int CNT_W         = 3;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAG_BYTES    = 2'd0,
        REG_TAG_LENGTH   = 2'd1,
        REG_VALUE_BYTES  = 2'd2,
        REG_VALUE_LENGTH = 2'd3
    } cfg_reg_t;

    // Configuration as seen by the sequencer, lengths already saturated.
    typedef struct packed {
        logic [WORD_W-1:0] tag_bytes;
        logic [LEN_W-1:0]  tag_len;
        logic [WORD_W-1:0] value_bytes;
        logic [LEN_W-1:0]  value_len;
    } cfg_t;

    // One result byte handed from the sequencer to the output register.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
    } emit_t;

    function automatic logic [LEN_W-1:0] tag_len_eff(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > LEN_W'(MAX_TAG_LEN)) begin
            res = LEN_W'(MAX_TAG_LEN);
        end
        return res;
    endfunction

    function automatic logic [LEN_W-1:0] value_len_eff(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len > LEN_W'(MAX_VALUE_LEN)) begin
            res = LEN_W'(MAX_VALUE_LEN);
        end
        return res;
    endfunction

endpackage

>>> rtl/core/stp_channels.sv
// Valid/ready channel interfaces for the item, result and configuration streams.
interface stp_in_if import stp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface stp_out_if import stp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

interface stp_cfg_if import stp_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/stream_tag_replace_top.sv
// Top level of the streaming tag find-and-replace block.
// The first result of an item is emitted once the sequencer has entered its run state, and
// it is then registered in the output register. Throughput: an item yields 0 to 8 results,
// stepped out one result per cycle, set by the single shared byte select unit, while the
// result side does not stall; the next item is taken once the last result is handed over.
// Reset: rst_n is asynchronous, active low; it empties the output register, idles the
// sequencer, zeroes the match count and returns the configuration registers to their reset values.
module stream_tag_replace_top
    import stp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    stp_in_if.sink    item,
    stp_out_if.source result,
    stp_cfg_if.sink   cfg
);

    // Configuration registers. Lengths are stored as written and saturated on use.
    logic [WORD_W-1:0] tag_bytes_reg;
    logic [LEN_W-1:0]  tag_length_reg;
    logic [WORD_W-1:0] value_bytes_reg;
    logic [LEN_W-1:0]  value_length_reg;

    logic              cfg_write;
    logic              clear_match;
    cfg_t              cfg_eff;
    emit_t             emit;
    logic              out_free;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_last_reg;

    // Write configuration only while the block is idle; not enforced. The port never stalls.
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    // Rewriting the tag or its length drops a partial match without emitting it.
    assign clear_match = cfg_write && ((cfg_reg_t'(cfg.index) == REG_TAG_BYTES) ||
                                       (cfg_reg_t'(cfg.index) == REG_TAG_LENGTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_bytes_reg    <= '0;
            tag_length_reg   <= LEN_W'(1);
            value_bytes_reg  <= '0;
            value_length_reg <= '0;
        end else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_TAG_BYTES:    tag_bytes_reg    <= cfg.data;
                REG_TAG_LENGTH:   tag_length_reg   <= cfg.data[LEN_W-1:0];
                REG_VALUE_BYTES:  value_bytes_reg  <= cfg.data;
                REG_VALUE_LENGTH: value_length_reg <= cfg.data[LEN_W-1:0];
                default:          tag_bytes_reg    <= tag_bytes_reg;
            endcase
        end
    end

    // A zero tag length behaves as one; both lengths saturate at their maximum.
    assign cfg_eff.tag_bytes   = tag_bytes_reg;
    assign cfg_eff.tag_len     = tag_len_eff(tag_length_reg);
    assign cfg_eff.value_bytes = value_bytes_reg;
    assign cfg_eff.value_len   = value_len_eff(value_length_reg);

    // The sequencer may hand over a byte when the output register is empty or
    // is being drained in this same cycle.
    assign out_free = !out_valid_reg || result.ready;

    stp_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cfg         (cfg_eff),
        .clear_match (clear_match),
        .out_free    (out_free),
        .emit        (emit)
    );

    // Output register: it decouples the result request from the sequencer, so
    // the next item can be taken while the final result still waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_byte_reg <= emit.data;
            run_last_reg <= emit.last;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.run_last = run_last_reg;

endmodule

>>> rtl/core/stp_byte_unit.sv
// Shared byte selector and comparator used for matching and for emission.
module stp_byte_unit
    import stp_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  logic [IDX_W-1:0]  idx,
    input  logic [BYTE_W-1:0] cmp,
    output logic [BYTE_W-1:0] sel,
    output logic              eq
);

    assign sel = word[idx*BYTE_W +: BYTE_W];
    assign eq  = (sel == cmp);

endmodule

>>> rtl/core/stp_seq.sv
// Match sequencer: plans each item's results and steps them out one per cycle while the output register is free.
`include "stream_tag_replace_top_assert.svh"
module stp_seq
    import stp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    stp_in_if.sink       item,
    input  cfg_t         cfg,
    input  logic         clear_match,
    input  logic         out_free,
    output emit_t        emit
);

    typedef enum logic {IDLE, RUN} state_t;
    typedef enum logic [1:0] {PH_HELD1, PH_MID, PH_HELD2} phase_t;
    typedef enum logic [1:0] {MID_NONE, MID_VALUE, MID_RAW} mid_kind_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    mid_kind_t         kind_reg, kind_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  len1_reg, len1_next;
    logic [LEN_W-1:0]  lenm_reg, lenm_next;
    logic [CNT_W-1:0]  len2_reg, len2_next;
    logic [BYTE_W-1:0] raw_reg, raw_next;
    logic [CNT_W-1:0]  match_count_reg, match_count_next;

    logic              accept;
    logic              advance;
    logic [CNT_W-1:0]  cnt0;
    logic [LEN_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  cnt_new;
    logic [CNT_W-1:0]  p_len1;
    logic [CNT_W-1:0]  p_len2;
    logic [LEN_W-1:0]  p_lenm;
    mid_kind_t         p_kind;
    logic [WORD_W-1:0] unit_word;
    logic [IDX_W-1:0]  unit_idx;
    logic [BYTE_W-1:0] unit_sel;
    logic              unit_eq;
    logic [LEN_W-1:0]  cur_len;
    logic              at_end;
    logic              done;

    assign item.ready = (state_reg == IDLE);
    assign accept     = item.valid && item.ready;
    assign advance    = (state_reg == RUN) && out_free;

    // A stale count at or above the tag length starts over from zero.
    assign cnt0 = ({1'b0, match_count_reg} >= cfg.tag_len) ? '0 : match_count_reg;

    // While idle the unit compares the incoming byte against the next tag byte;
    // while running it fetches the byte to emit.
    assign unit_word = ((state_reg == RUN) && (phase_reg == PH_MID)) ? cfg.value_bytes
                                                                     : cfg.tag_bytes;
    assign unit_idx  = (state_reg == RUN) ? idx_reg : cnt0;

    stp_byte_unit u_byte_unit (
        .word (unit_word),
        .idx  (unit_idx),
        .cmp  (item.in_byte),
        .sel  (unit_sel),
        .eq   (unit_eq)
    );

    // Plan of one item: held prefix, then value or raw byte, then flushed prefix.
    always_comb
    begin
        cnt_inc = {1'b0, cnt0} + LEN_W'(1);
        p_len1  = '0;
        p_lenm  = '0;
        p_kind  = MID_NONE;
        cnt_new = '0;
        if (unit_eq)
        begin
            if (cnt_inc >= cfg.tag_len)
            begin
                p_kind = MID_VALUE;
                p_lenm = cfg.value_len;
            end else begin
                cnt_new = cnt_inc[CNT_W-1:0];
            end
        end else if (cnt0 != '0)
        begin
            p_len1 = cnt0;
            if (item.in_byte == cfg.tag_bytes[BYTE_W-1:0])
            begin
                cnt_new = CNT_W'(1);
            end else begin
                p_kind = MID_RAW;
                p_lenm = LEN_W'(1);
            end
        end else begin
            p_kind = MID_RAW;
            p_lenm = LEN_W'(1);
        end
        p_len2 = item.stream_end ? cnt_new : '0;
    end

    // Phase bookkeeping while running.
    always_comb
    begin
        unique case (phase_reg)
            PH_HELD1: cur_len = {1'b0, len1_reg};
            PH_MID:   cur_len = lenm_reg;
            PH_HELD2: cur_len = {1'b0, len2_reg};
            default:  cur_len = '0;
        endcase
        at_end = ({1'b0, idx_reg} == (cur_len - LEN_W'(1)));
        unique case (phase_reg)
            PH_HELD1: done = (lenm_reg == '0) && (len2_reg == '0);
            PH_MID:   done = (len2_reg == '0);
            default:  done = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        len1_next        = len1_reg;
        lenm_next        = lenm_reg;
        len2_next        = len2_reg;
        raw_next         = raw_reg;
        match_count_next = match_count_reg;
        if (clear_match)
        begin
            match_count_next = '0;
        end
        unique case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    kind_next        = p_kind;
                    len1_next        = p_len1;
                    lenm_next        = p_lenm;
                    len2_next        = p_len2;
                    raw_next         = item.in_byte;
                    idx_next         = '0;
                    match_count_next = item.stream_end ? '0 : cnt_new;
                    priority if (p_len1 != '0)
                    begin
                        phase_next = PH_HELD1;
                        state_next = RUN;
                    end else if (p_lenm != '0)
                    begin
                        phase_next = PH_MID;
                        state_next = RUN;
                    end else if (p_len2 != '0)
                    begin
                        phase_next = PH_HELD2;
                        state_next = RUN;
                    end
                end
            end
            RUN:
            begin
                if (advance)
                begin
                    if (!at_end)
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end else begin
                        idx_next = '0;
                        priority if (done)
                        begin
                            state_next = IDLE;
                        end else if ((phase_reg == PH_HELD1) && (lenm_reg != '0))
                        begin
                            phase_next = PH_MID;
                        end else begin
                            phase_next = PH_HELD2;
                        end
                    end
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            phase_reg       <= PH_HELD1;
            kind_reg        <= MID_NONE;
            idx_reg         <= '0;
            len1_reg        <= '0;
            lenm_reg        <= '0;
            len2_reg        <= '0;
            match_count_reg <= '0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            kind_reg        <= kind_next;
            idx_reg         <= idx_next;
            len1_reg        <= len1_next;
            lenm_reg        <= lenm_next;
            len2_reg        <= len2_next;
            match_count_reg <= match_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
    end

    assign emit.valid = advance;
    assign emit.data  = ((phase_reg == PH_MID) && (kind_reg == MID_RAW)) ? raw_reg : unit_sel;
    assign emit.last  = at_end && done;

    `STP_ASSERT_NOW(a_count_below_len, 1'b1, {1'b0, match_count_reg} < cfg.tag_len)
    `STP_ASSERT_NEXT(a_end_flushes, accept && item.stream_end, match_count_reg == '0)
    `STP_ASSERT_NEXT(a_last_goes_idle, emit.valid && emit.last, state_reg == IDLE)
    `STP_ASSERT_NEXT(a_stall_holds, (state_reg == RUN) && !out_free,
                     $stable(idx_reg) && $stable(phase_reg) && (state_reg == RUN))

endmodule
